// ===== design/md5p_pkg.sv =====
// Shared types and constants for the MD5 message padder.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package md5p_pkg;

	// Block geometry: 64 bytes, sixteen 32-bit words.
	localparam int BLOCK_BYTES  = 64;
	localparam int POS_W        = $clog2(BLOCK_BYTES);
	localparam int IDX_W        = POS_W - 2;
	localparam int COUNT_W      = 61;
	localparam int WORD_W       = 32;
	localparam int IN_TDATA_W   = 8;
	localparam int IN_TUSER_W   = 1;
	localparam int OUT_TDATA_W  = 40;

	// Word positions of the 64-bit length field at the end of a block.
	localparam logic [IDX_W-1:0] LEN_LO_IDX = IDX_W'(BLOCK_BYTES / 4 - 2);
	localparam logic [IDX_W-1:0] LEN_HI_IDX = IDX_W'(BLOCK_BYTES / 4 - 1);

	// First byte position that leaves no room for the length field.
	localparam logic [POS_W:0] LEN_START_POS = (POS_W + 1)'(BLOCK_BYTES - 8);

	localparam logic [7:0] PAD_MARK = 8'h80;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;  // an input item is accepted this cycle
		logic pad_word;   // emit the next padding or length word
	} md5p_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;   // output register can take a word this cycle
		logic pad_final;  // the next padding word is the final length word
	} md5p_sts_t;

endpackage

`default_nettype wire

// ===== design/md5p_ctrl.sv =====
// Controller state machine of the MD5 message padder.
// Depends on md5p_pkg; drives the datapath through md5p_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module md5p_ctrl import md5p_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	input  wire logic      s_tlast,
	output logic           s_tready,
	input  md5p_sts_t      sts,
	output md5p_cmd_t      cmd
);

	localparam logic ST_ACCEPT = 1'b0;
	localparam logic ST_PAD    = 1'b1;

	logic state_q;
	logic state_n;

	// Items are taken only while collecting bytes and the output can move.
	always_comb begin
		s_tready      = (state_q == ST_ACCEPT) && sts.out_free;
		cmd.load_item = s_tvalid && s_tready;
		cmd.pad_word  = (state_q == ST_PAD) && sts.out_free;
	end

	// Next state: the end-of-message item starts padding, the length word ends it.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_ACCEPT: begin
				if (cmd.load_item && s_tlast) begin
					state_n = ST_PAD;
				end
			end
			ST_PAD: begin
				if (cmd.pad_word && sts.pad_final) begin
					state_n = ST_ACCEPT;
				end
			end
			default: state_n = ST_ACCEPT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCEPT;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

`default_nettype wire

// ===== design/md5p_dp.sv =====
// Datapath of the MD5 message padder: word assembly, byte count and output register.
// Depends on md5p_pkg; controlled by md5p_ctrl through md5p_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module md5p_dp import md5p_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  md5p_cmd_t                   cmd,
	output md5p_sts_t                   sts,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	input  wire logic [IN_TUSER_W-1:0]  s_tuser,
	input  wire logic                   s_tlast,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	output logic                        m_tlast
);

	logic [23:0]        partial_q;
	logic [POS_W-1:0]   pos_q;
	logic [COUNT_W-1:0] count_q;
	logic               pad_first_q;
	logic               len_ok_q;
	logic               out_valid_q;
	logic [WORD_W-1:0]  out_word_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic               out_last_q;

	logic [1:0]         lane;
	logic [IDX_W-1:0]   idx;
	logic [7:0]         in_byte;
	logic               has_byte;
	logic [WORD_W-1:0]  byte_ins;
	logic [WORD_W-1:0]  mark_ins;
	logic               word_done;
	logic [POS_W:0]     pos_after;
	logic [WORD_W-1:0]  pad_word;
	logic               emit;
	logic [WORD_W-1:0]  emit_word;
	logic [IDX_W-1:0]   emit_idx;
	logic               emit_last;

	assign lane     = pos_q[1:0];
	assign idx      = pos_q[POS_W-1:2];
	assign in_byte  = s_tdata[7:0];
	assign has_byte = s_tuser[0];

	// Byte and end marker placed at the current lane of the word.
	always_comb begin
		byte_ins  = WORD_W'(in_byte) << {lane, 3'b000};
		mark_ins  = WORD_W'(PAD_MARK) << {lane, 3'b000};
		word_done = has_byte && (lane == 2'd3);
		pos_after = {1'b0, pos_q} + (POS_W + 1)'(has_byte);
	end

	// Padding word: marker word first, then zeros, then the bit length.
	always_comb begin
		pad_word = '0;
		if (pad_first_q) begin
			pad_word = {8'h00, partial_q} | mark_ins;
		end else if (len_ok_q && (idx == LEN_LO_IDX)) begin
			pad_word = {count_q[28:0], 3'b000};
		end else if (len_ok_q && (idx == LEN_HI_IDX)) begin
			pad_word = count_q[COUNT_W-1:29];
		end
	end

	assign sts.out_free  = !out_valid_q || m_tready;
	assign sts.pad_final = len_ok_q && (idx == LEN_HI_IDX);

	// Word going into the output register this cycle, if any.
	always_comb begin
		emit      = (cmd.load_item && word_done) || cmd.pad_word;
		emit_word = cmd.pad_word ? pad_word : {in_byte, partial_q};
		emit_idx  = idx;
		emit_last = cmd.pad_word && sts.pad_final;
	end

	// Message state: partial word, byte position, byte count, padding flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q   <= '0;
			pos_q       <= '0;
			count_q     <= '0;
			pad_first_q <= 1'b0;
			len_ok_q    <= 1'b0;
		end else if (cmd.load_item) begin
			if (has_byte) begin
				partial_q <= word_done ? 24'h000000 : (partial_q | byte_ins[23:0]);
				pos_q     <= pos_after[POS_W-1:0];
				count_q   <= count_q + COUNT_W'(1);
			end
			if (s_tlast) begin
				pad_first_q <= 1'b1;
				len_ok_q    <= ({1'b0, pos_after[POS_W-1:0]} < LEN_START_POS);
			end
		end else if (cmd.pad_word) begin
			if (sts.pad_final) begin
				partial_q   <= '0;
				pos_q       <= '0;
				count_q     <= '0;
				pad_first_q <= 1'b0;
				len_ok_q    <= 1'b0;
			end else begin
				partial_q   <= '0;
				pos_q       <= {idx + IDX_W'(1), 2'b00};
				pad_first_q <= 1'b0;
				if (idx == LEN_HI_IDX) begin
					len_ok_q <= 1'b1;
				end
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_word_q <= emit_word;
			out_idx_q  <= emit_idx;
			out_last_q <= emit_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - WORD_W - IDX_W){1'b0}}, out_idx_q, out_word_q};
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

// ===== design/md5_message_padder_top.sv =====
// Top level of the MD5 message padder: byte stream in, padded 32-bit word stream out.
// Depends on md5p_pkg, md5p_ctrl and md5p_dp.
//
// Channel | Direction | tdata (low bit up)        | tuser        | tlast
// s_*     | in        | byte_value[7:0]           | has_byte[0]  | is_last
// m_*     | out       | word[31:0], word_index[35:32], zeros | - | last_of_run
//
// Message bytes are taken one per cycle while the output register can move.
// The end-of-message item is followed by 3 to 18 padding and length words,
// one per cycle while the output register can move, emitted by the controller's padding state; no item is taken then.
// A single output register parts the two sides; m_tready low while it holds a word stalls both.
// Reset is asynchronous and active low and clears all message state.
`timescale 1ns / 1ps
`default_nettype none

module md5_message_padder_top import md5p_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // byte_value[7:0]
	input  wire logic [IN_TUSER_W-1:0]  s_tuser,   // has_byte[0]
	input  wire logic                   s_tlast,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,   // word[31:0], word_index[35:32], zero[39:36]
	output logic                        m_tlast
);

	md5p_cmd_t cmd;
	md5p_sts_t sts;

	// Sequencing of byte intake and padding.
	md5p_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Word assembly, length counter and output register.
	md5p_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire
